/* hw/rtl/ipr_pkg.sv */
// shared types, widths and helpers for the integer partition ranking block
// no dependencies
package ipr_pkg;

    // fixed field widths
    localparam int RANK_W        = 48;
    localparam int CELL_W        = 7;
    // widest triangular table index for the largest supported cell count
    localparam int TRI_W         = 14;
    localparam int MAX_CELLS_DEF = 64;

    // one memory port request: write side and read side
    typedef struct packed {
        logic              we;
        logic [TRI_W-1:0]  waddr;
        logic [RANK_W-1:0] wdata;
        logic              re;
        logic [TRI_W-1:0]  raddr;
    } t_ram_req;

    // first entry of row n in the triangular table: n*(n+1)/2
    function automatic logic [TRI_W-1:0] tri_base(input logic [CELL_W-1:0] n);
        logic [TRI_W:0] nn;
        logic [TRI_W:0] prod;
        nn   = (TRI_W+1)'(n);
        prod = nn * (nn + 1'b1);
        return prod[TRI_W:1];
    endfunction

endpackage

/* hw/rtl/integer_partition_rank_top.sv */
// integer partition ranking, top level: two rams, fill sequencer, ranking datapath
// a beat with last set goes through the lookup stage, then the output register
// throughput: one part per cycle unless o_in_stall is high; a table read is
// issued at accept for each part that adds a table term to the rank
// reset: synchronous, active low; afterwards the table fill runs, input stalled
// depends on ipr_pkg, ipr_ram, ipr_fill, ipr_rank
module integer_partition_rank_top #(
    parameter int MAX_CELLS = ipr_pkg::MAX_CELLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_start_req,
    input  logic [ipr_pkg::CELL_W-1:0] i_total_cells,
    input  logic [ipr_pkg::CELL_W-1:0] i_part,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ipr_pkg::RANK_W-1:0] o_rank,
    output logic                       o_error
);

    localparam int TBL_DEPTH = MAX_CELLS * (MAX_CELLS + 1) / 2;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int TOT_AW    = $clog2(MAX_CELLS);

    ipr_pkg::t_ram_req          fill_tbl;
    ipr_pkg::t_ram_req          fill_tot;
    ipr_pkg::t_ram_req          rank_tbl;
    ipr_pkg::t_ram_req          rank_tot;
    ipr_pkg::t_ram_req          tbl_req;
    ipr_pkg::t_ram_req          tot_req;
    logic                       fill_done;
    logic [ipr_pkg::RANK_W-1:0] tbl_rdata;
    logic [ipr_pkg::RANK_W-1:0] tot_rdata;

    // ram ports belong to the fill until it finishes, then to the ranking side;
    // writes and reads never overlap, so no forwarding is needed
    assign tbl_req = fill_done ? rank_tbl : fill_tbl;
    assign tot_req = fill_done ? rank_tot : fill_tot;

    // partition count table, triangular layout
    ipr_ram #(
        .WIDTH (ipr_pkg::RANK_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_req.we),
        .i_waddr (tbl_req.waddr[TBL_AW-1:0]),
        .i_wdata (tbl_req.wdata),
        .i_re    (tbl_req.re),
        .i_raddr (tbl_req.raddr[TBL_AW-1:0]),
        .o_rdata (tbl_rdata)
    );

    // running totals of all partitions of smaller sizes
    ipr_ram #(
        .WIDTH (ipr_pkg::RANK_W),
        .DEPTH (MAX_CELLS)
    ) u_tot_ram (
        .i_clk   (i_clk),
        .i_we    (tot_req.we),
        .i_waddr (tot_req.waddr[TOT_AW-1:0]),
        .i_wdata (tot_req.wdata),
        .i_re    (tot_req.re),
        .i_raddr (tot_req.raddr[TOT_AW-1:0]),
        .o_rdata (tot_rdata)
    );

    ipr_fill #(
        .MAX_CELLS (MAX_CELLS)
    ) u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_data (tbl_rdata),
        .o_tbl     (fill_tbl),
        .o_tot     (fill_tot),
        .o_done    (fill_done)
    );

    ipr_rank #(
        .MAX_CELLS (MAX_CELLS)
    ) u_rank (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (fill_done),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_start_req   (i_start_req),
        .i_total_cells (i_total_cells),
        .i_part        (i_part),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rank        (o_rank),
        .o_error       (o_error),
        .o_tbl         (rank_tbl),
        .o_tot         (rank_tot),
        .i_tbl_data    (tbl_rdata),
        .i_tot_data    (tot_rdata)
    );

endmodule

/* hw/rtl/ipr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module ipr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ipr_fill.sv */
// table fill sequencer: builds the partition count table and the running totals
// depends on ipr_pkg
module ipr_fill #(
    parameter int MAX_CELLS = ipr_pkg::MAX_CELLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ipr_pkg::RANK_W-1:0] i_rd_data,
    output ipr_pkg::t_ram_req         o_tbl,
    output ipr_pkg::t_ram_req         o_tot,
    output logic                      o_done
);

    localparam int N_W = $clog2(MAX_CELLS);
    localparam logic [N_W-1:0] N_LAST = N_W'(MAX_CELLS - 1);
    localparam logic [N_W-1:0] N_ONE  = N_W'(1);

    typedef enum logic [2:0] {
        F_ROW,
        F_RD,
        F_WR,
        F_DIAG,
        F_DONE
    } t_fill_state;

    t_fill_state                r_state;
    logic [N_W-1:0]             r_n;
    logic [N_W-1:0]             r_k;
    logic [ipr_pkg::TRI_W-1:0]  r_base;
    logic [ipr_pkg::RANK_W-1:0] r_prev;
    logic [ipr_pkg::RANK_W-1:0] r_acc;

    logic [N_W-1:0]             src_row;
    logic [N_W-1:0]             src_col;
    logic [ipr_pkg::RANK_W-1:0] wval;
    logic [ipr_pkg::TRI_W-1:0]  next_base;

    // source entry of the recurrence: row n-k-1, column min(k, n-k-1)
    always_comb begin
        src_row   = r_n - r_k - N_ONE;
        src_col   = ({1'b0, r_n} > {r_k, 1'b0}) ? r_k : src_row;
        next_base = r_base + ipr_pkg::TRI_W'(r_n) + 1'b1;
    end

    // value written this cycle
    always_comb begin
        case (r_state)
            F_ROW:   wval = ipr_pkg::RANK_W'(1);
            F_WR:    wval = r_prev + i_rd_data;
            F_DIAG:  wval = r_prev + 1'b1;
            default: wval = '0;
        endcase
    end

    // memory port requests
    always_comb begin
        o_tbl.we    = (r_state == F_ROW) || (r_state == F_WR) || (r_state == F_DIAG);
        o_tbl.wdata = wval;
        case (r_state)
            F_WR:    o_tbl.waddr = r_base + ipr_pkg::TRI_W'(r_k);
            F_DIAG:  o_tbl.waddr = r_base + ipr_pkg::TRI_W'(r_n);
            default: o_tbl.waddr = r_base;
        endcase
        o_tbl.re    = (r_state == F_RD);
        o_tbl.raddr = ipr_pkg::tri_base(ipr_pkg::CELL_W'(src_row))
                      + ipr_pkg::TRI_W'(src_col);

        o_tot.we    = (r_state == F_ROW);
        o_tot.waddr = ipr_pkg::TRI_W'(r_n);
        o_tot.wdata = r_acc;
        o_tot.re    = 1'b0;
        o_tot.raddr = '0;
    end

    assign o_done = (r_state == F_DONE);

    // sequencer: row start, read/write pairs per column, diagonal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_ROW;
            r_n     <= '0;
            r_k     <= '0;
            r_base  <= '0;
            r_prev  <= '0;
            r_acc   <= '0;
        end else begin
            case (r_state)
                F_ROW: begin
                    r_prev <= wval;
                    if (r_n == '0) begin
                        // single-cell row is its own diagonal
                        r_acc  <= r_acc + wval;
                        r_n    <= r_n + N_ONE;
                        r_base <= next_base;
                    end else if (r_n == N_ONE) begin
                        r_state <= F_DIAG;
                    end else begin
                        r_k     <= N_ONE;
                        r_state <= F_RD;
                    end
                end
                F_RD: begin
                    r_state <= F_WR;
                end
                F_WR: begin
                    r_prev <= wval;
                    if (r_k + N_ONE == r_n) begin
                        r_state <= F_DIAG;
                    end else begin
                        r_k     <= r_k + N_ONE;
                        r_state <= F_RD;
                    end
                end
                F_DIAG: begin
                    r_acc <= r_acc + wval;
                    if (r_n == N_LAST) begin
                        r_state <= F_DONE;
                    end else begin
                        r_n     <= r_n + N_ONE;
                        r_base  <= next_base;
                        r_state <= F_ROW;
                    end
                end
                F_DONE: begin
                    r_state <= F_DONE;
                end
                default: begin
                    r_state <= F_DONE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ipr_rank.sv */
// ranking datapath: per-part checks, table lookup and rank accumulation
// depends on ipr_pkg
module ipr_rank #(
    parameter int MAX_CELLS = ipr_pkg::MAX_CELLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_enable,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_start_req,
    input  logic [ipr_pkg::CELL_W-1:0] i_total_cells,
    input  logic [ipr_pkg::CELL_W-1:0] i_part,
    input  logic                       i_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ipr_pkg::RANK_W-1:0] o_rank,
    output logic                       o_error,
    output ipr_pkg::t_ram_req          o_tbl,
    output ipr_pkg::t_ram_req          o_tot,
    input  logic [ipr_pkg::RANK_W-1:0] i_tbl_data,
    input  logic [ipr_pkg::RANK_W-1:0] i_tot_data
);

    localparam int CW = ipr_pkg::CELL_W;
    localparam logic [CW:0]   MAX_V    = (CW+1)'(MAX_CELLS);
    localparam logic [CW-1:0] ONE_C    = CW'(1);
    localparam logic [CW-1:0] TWO_C    = CW'(2);

    // part state
    logic [CW-1:0]              r_rem;
    logic [CW-1:0]              r_prev;
    logic                       r_ones;
    logic                       r_err;
    logic [ipr_pkg::RANK_W-1:0] r_rank;

    // lookup stage
    logic r_s1_valid;
    logic r_s1_start;
    logic r_s1_bad;
    logic r_s1_add;
    logic r_s1_last;
    logic r_s1_err;

    // output register
    logic                       r_o_valid;
    logic [ipr_pkg::RANK_W-1:0] r_o_rank;
    logic                       r_o_error;

    logic          accept;
    logic          s1_adv;
    logic          bad;
    logic          add;
    logic [CW-1:0] start_rem;
    logic [CW-1:0] n_rem;
    logic [CW-1:0] n_prev;
    logic          n_ones;
    logic          n_err;
    logic [ipr_pkg::RANK_W-1:0] sum_a;
    logic [ipr_pkg::RANK_W-1:0] sum_b;
    logic [ipr_pkg::RANK_W-1:0] n_rank;

    // hold the input during the table fill and while a closing beat waits behind a stalled result
    assign o_in_stall = !i_enable || (r_s1_valid && r_s1_last && r_o_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign s1_adv     = r_s1_valid && (!r_s1_last || !r_o_valid || !i_out_stall);

    // checks and cell bookkeeping for the incoming beat
    always_comb begin
        bad       = (i_total_cells == '0) || ({1'b0, i_total_cells} > MAX_V);
        start_rem = '0;
        n_rem     = r_rem;
        n_prev    = r_prev;
        n_ones    = r_ones;
        n_err     = r_err;
        add       = 1'b0;
        if (i_start_req) begin
            n_ones = 1'b0;
            if (bad) begin
                n_err  = 1'b1;
                n_rem  = '0;
                n_prev = '1;
            end else begin
                n_err  = 1'b0;
                n_rem  = i_total_cells;
                n_prev = i_total_cells;
            end
        end
        start_rem = n_rem;
        if (!n_ones) begin
            if (i_part == '0) begin
                n_err = 1'b1;
            end else begin
                if (i_part > n_prev) begin
                    n_err = 1'b1;
                end
                if (i_part == ONE_C) begin
                    n_ones = 1'b1;
                end else if (i_part > n_rem) begin
                    n_err = 1'b1;
                end else begin
                    add   = 1'b1;
                    n_rem = n_rem - i_part;
                end
                n_prev = i_part;
            end
        end
    end

    // lookups: table entry for this part, running total for the new size
    always_comb begin
        o_tbl.we    = 1'b0;
        o_tbl.waddr = '0;
        o_tbl.wdata = '0;
        o_tbl.re    = accept && add;
        o_tbl.raddr = ipr_pkg::tri_base(start_rem - ONE_C)
                      + ipr_pkg::TRI_W'(i_part - TWO_C);
        o_tot.we    = 1'b0;
        o_tot.waddr = '0;
        o_tot.wdata = '0;
        o_tot.re    = accept && i_start_req && !bad;
        o_tot.raddr = ipr_pkg::TRI_W'(i_total_cells - ONE_C);
    end

    // rank update: base (restart or running) plus optional table term, plus one on a restart
    always_comb begin
        if (r_s1_start) begin
            sum_a = r_s1_bad ? '0 : i_tot_data;
        end else begin
            sum_a = r_rank;
        end
        sum_b  = r_s1_add ? i_tbl_data : '0;
        n_rank = sum_a + sum_b + ipr_pkg::RANK_W'(r_s1_start);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem      <= '0;
            r_prev     <= '0;
            r_ones     <= 1'b0;
            r_err      <= 1'b0;
            r_rank     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_rem  <= n_rem;
                r_prev <= n_prev;
                r_ones <= n_ones;
                r_err  <= n_err;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_rank <= n_rank;
            end
            if (s1_adv && r_s1_last) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_start <= i_start_req;
            r_s1_bad   <= bad;
            r_s1_add   <= add;
            r_s1_last  <= i_last;
            r_s1_err   <= n_err;
        end
        if (s1_adv && r_s1_last) begin
            r_o_rank  <= n_rank;
            r_o_error <= r_s1_err;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_rank      = r_o_rank;
    assign o_error     = r_o_error;

endmodule

/* sim/partition_rank_checker.sv */
`timescale 1ns / 1ps
// checker for the integer partition ranking block: watches both channels,
// predicts each rank from its own count tables and compares field by field
// depends on ipr_pkg for field widths and the default cell limit
module partition_rank_checker #(
    parameter int MAX_CELLS = ipr_pkg::MAX_CELLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_start_req,
    input  logic [ipr_pkg::CELL_W-1:0] i_total_cells,
    input  logic [ipr_pkg::CELL_W-1:0] i_part,
    input  logic                       i_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [ipr_pkg::RANK_W-1:0] i_rank,
    input  logic                       i_error,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int CELL_W    = ipr_pkg::CELL_W;
    localparam int RANK_W    = ipr_pkg::RANK_W;
    localparam int DUE_DEPTH = 64;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              error;
    } t_ranked;

    // partitions of n+1 cells with largest part at most k+1
    logic [RANK_W-1:0] part_counts [MAX_CELLS][MAX_CELLS];
    // number of all partitions with fewer cells than n+1
    logic [RANK_W-1:0] totals_below [MAX_CELLS];

    // running state of the diagram being ranked
    logic [CELL_W-1:0] rem_cells;
    logic [CELL_W-1:0] prev_part;
    logic [RANK_W-1:0] rank_acc;
    logic              ones_seen;
    logic              err_seen;

    // ranks predicted but not yet seen on the result side, in order
    t_ranked ranks_due [DUE_DEPTH];
    int      due_wr     = 0;
    int      due_rd     = 0;
    int      mismatches = 0;

    // count tables by the usual partition recurrence
    function automatic void build_count_tables();
        logic [RANK_W-1:0] acc;
        logic [RANK_W-1:0] add;
        acc = '0;
        for (int n = 0; n < MAX_CELLS; n++)
            for (int k = 0; k < MAX_CELLS; k++)
                part_counts[n][k] = '0;
        part_counts[0][0] = 1;
        for (int n = 1; n < MAX_CELLS; n++) begin
            part_counts[n][0] = 1;
            for (int k = 1; k < n; k++) begin
                if (n > 2 * k)
                    add = part_counts[n-k-1][k];
                else
                    add = part_counts[n-k-1][n-k-1];
                part_counts[n][k] = part_counts[n][k-1] + add;
            end
            part_counts[n][n] = part_counts[n][n-1] + 1;
        end
        for (int n = 0; n < MAX_CELLS; n++) begin
            totals_below[n] = acc;
            acc = acc + part_counts[n][n];
        end
    endfunction

    // advance the rank by one column beat, queue a rank on the closing beat
    function automatic void rank_column(input logic start, input logic [CELL_W-1:0] total,
                                        input logic [CELL_W-1:0] part, input logic last);
        int row;
        int col;
        if (start) begin
            ones_seen = 1'b0;
            err_seen  = 1'b0;
            if (total == 0 || total > MAX_CELLS) begin
                err_seen  = 1'b1;
                rank_acc  = 1;
                rem_cells = '0;
                prev_part = '1;
            end else begin
                rank_acc  = totals_below[total-1] + 1;
                rem_cells = total;
                prev_part = total;
            end
        end
        if (!ones_seen) begin
            if (part == 0) begin
                err_seen = 1'b1;
            end else begin
                if (part > prev_part)
                    err_seen = 1'b1;
                if (part == 1) begin
                    ones_seen = 1'b1;
                end else if (part > rem_cells) begin
                    err_seen = 1'b1;
                end else begin
                    row       = int'(rem_cells) - 1;
                    col       = int'(part) - 2;
                    rank_acc  = rank_acc + part_counts[row][col];
                    rem_cells = rem_cells - part;
                end
                prev_part = part;
            end
        end
        if (last) begin
            ranks_due[due_wr % DUE_DEPTH] = '{rank: rank_acc, error: err_seen};
            due_wr++;
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [RANK_W-1:0] want,
                                            input logic [RANK_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("rank check: %s mismatch, expected %0d got %0d", what, want, got);
    endfunction

    initial begin
        build_count_tables();
    end

    // sample both channels at the rising edge, result side first
    always @(posedge i_clk) begin
        t_ranked want;
        if (!i_rst_n) begin
            rem_cells = '0;
            prev_part = '0;
            rank_acc  = '0;
            ones_seen = 1'b0;
            err_seen  = 1'b0;
            due_wr    = 0;
            due_rd    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_wr == due_rd) begin
                    report_mismatch("unexpected result beat, rank", '0, i_rank);
                end else begin
                    want = ranks_due[due_rd % DUE_DEPTH];
                    due_rd++;
                    if (i_rank !== want.rank)
                        report_mismatch("rank", want.rank, i_rank);
                    if (i_error !== want.error)
                        report_mismatch("error flag", RANK_W'(want.error), RANK_W'(i_error));
                end
            end
            if (i_in_valid && !i_in_stall)
                rank_column(i_start_req, i_total_cells, i_part, i_last);
        end
        o_fail_count <= mismatches;
        o_pending    <= due_wr - due_rd;
    end

endmodule

/* sim/integer_partition_rank_top_tb.sv */
`timescale 1ns / 1ps
// testbench top for integer_partition_rank_top: clock, reset, column beats and
// result stalls; checking is done by partition_rank_checker beside the block
// depends on ipr_pkg, partition_rank_checker and the block's rtl
module integer_partition_rank_top_tb;

    localparam int CELL_W      = ipr_pkg::CELL_W;
    localparam int RANK_W      = ipr_pkg::RANK_W;
    localparam int MAX_CELLS   = ipr_pkg::MAX_CELLS_DEF;
    localparam int HOLD_CYCLES = 400;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              start_req  = 1'b0;
    logic [CELL_W-1:0] total_cells = '0;
    logic [CELL_W-1:0] part       = '0;
    logic              last       = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [RANK_W-1:0] rank;
    logic              error;

    int fail_count;
    int pending;
    int beats_sent = 0;
    bit tight_sender   = 1'b0;
    bit tight_receiver = 1'b0;
    bit hold_request   = 1'b0;

    integer_partition_rank_top #(
        .MAX_CELLS(MAX_CELLS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_start_req  (start_req),
        .i_total_cells(total_cells),
        .i_part       (part),
        .i_last       (last),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_rank       (rank),
        .o_error      (error)
    );

    partition_rank_checker #(
        .MAX_CELLS(MAX_CELLS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_start_req  (start_req),
        .i_total_cells(total_cells),
        .i_part       (part),
        .i_last       (last),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_rank       (rank),
        .i_error      (error),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // offer one column beat after a random gap and hold it until taken
    task automatic send_beat(input logic start, input logic [CELL_W-1:0] total,
                             input logic [CELL_W-1:0] height, input logic closing);
        int gap;
        gap = tight_sender ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge i_clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid    <= 1'b1;
        start_req   <= start;
        total_cells <= total;
        part        <= height;
        last        <= closing;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic release_input();
        @(negedge i_clk) in_valid <= 1'b0;
    endtask

    task automatic wait_all_ranked();
        while (pending != 0) @(posedge i_clk);
    endtask

    // well-formed diagram: non-increasing parts, sometimes cut short or ending in ones
    task automatic send_partition();
        int   total;
        int   rem;
        int   prev;
        int   p;
        int   hi;
        logic first;
        logic done;
        total = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, MAX_CELLS);
        rem   = total;
        prev  = total;
        first = 1'b1;
        done  = 1'b0;
        while (!done) begin
            hi = (prev < rem) ? prev : rem;
            p  = $urandom_range(1, hi);
            if (p > 1 && $urandom_range(0, 3) == 0)
                p = hi;
            rem  = rem - p;
            prev = p;
            done = (rem == 0) || ($urandom_range(0, 15) == 0) ||
                   (p == 1 && $urandom_range(0, 1) == 0);
            send_beat(first, CELL_W'(total), CELL_W'(p), done);
            beats_sent++;
            first = 1'b0;
        end
    endtask

    // broken sequences: wild totals and parts, missing starts, stray closing beats
    task automatic send_scramble();
        int   n;
        logic start;
        logic [CELL_W-1:0] total;
        logic [CELL_W-1:0] height;
        n = $urandom_range(1, 6);
        for (int k = 1; k <= n; k++) begin
            start  = (k == 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
            total  = $urandom_range(0, 1) ? CELL_W'($urandom_range(0, 127))
                                          : CELL_W'($urandom_range(1, MAX_CELLS));
            height = $urandom_range(0, 1) ? CELL_W'($urandom_range(0, 127))
                                          : CELL_W'($urandom_range(0, 8));
            send_beat(start, total, height, (k == n) || ($urandom_range(0, 7) == 0));
            beats_sent++;
        end
    endtask

    // result side: random stall per result, one long hold-off on request
    initial begin
        int n;
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            if (hold_request && !hold_taken) begin
                n          = HOLD_CYCLES;
                hold_taken = 1'b1;
            end else begin
                n = tight_receiver ? 0 : $urandom_range(0, 13);
            end
            if (n > 0) begin
                @(negedge i_clk) out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk) out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
        end
    end

    // stimulus and verdict
    initial begin
        int waited;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: beats before any start, extremes, each error kind
        send_beat(1'b0, 7'd0, 7'd3, 1'b1);
        send_beat(1'b0, 7'd0, 7'd1, 1'b1);
        send_beat(1'b1, 7'd1, 7'd1, 1'b1);
        send_beat(1'b1, 7'd64, 7'd64, 1'b1);
        send_beat(1'b1, 7'd64, 7'd1, 1'b1);
        send_beat(1'b1, 7'd64, 7'd63, 1'b0);
        send_beat(1'b0, 7'd0, 7'd1, 1'b1);
        // bad totals
        send_beat(1'b1, 7'd0, 7'd1, 1'b1);
        send_beat(1'b1, 7'd65, 7'd2, 1'b1);
        send_beat(1'b1, 7'd127, 7'd127, 1'b1);
        // rising part
        send_beat(1'b1, 7'd10, 7'd3, 1'b0);
        send_beat(1'b0, 7'd0, 7'd5, 1'b1);
        // overrun of the remaining cells
        send_beat(1'b1, 7'd5, 7'd4, 1'b0);
        send_beat(1'b0, 7'd0, 7'd3, 1'b1);
        // zero part
        send_beat(1'b1, 7'd6, 7'd0, 1'b0);
        send_beat(1'b0, 7'd0, 7'd2, 1'b1);
        // parts after a one are ignored
        send_beat(1'b1, 7'd8, 7'd3, 1'b0);
        send_beat(1'b0, 7'd0, 7'd1, 1'b0);
        send_beat(1'b0, 7'd0, 7'd7, 1'b1);
        // short sum, then a beat continuing after the closing one
        send_beat(1'b1, 7'd9, 7'd4, 1'b1);
        send_beat(1'b0, 7'd127, 7'd2, 1'b1);
        beats_sent = 21;
        release_input();
        wait_all_ranked();

        // random phases with tight, held and paused stretches
        for (int phase = 0; phase < 8; phase++) begin
            tight_sender   = (phase == 1) || (phase == 4);
            tight_receiver = (phase == 1) || (phase == 6);
            if (phase == 4)
                hold_request = 1'b1;
            while (beats_sent < 21 + (phase + 1) * 241) begin
                if ($urandom_range(0, 99) < 85)
                    send_partition();
                else
                    send_scramble();
            end
            if (phase == 2 || phase == 5) begin
                release_input();
                wait_all_ranked();
            end
        end
        release_input();

        // drain, then allow for the pipeline
        waited = 0;
        while (pending != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
